// ===== rtl/rpst_pkg.sv =====
// Shared types, constants and sign helpers for the range product sign tree.
`timescale 1ns / 1ps
`default_nettype none

package rpst_pkg;

    localparam int ELEMENTS  = 1024;
    localparam int IDX_W     = $clog2(ELEMENTS);
    localparam int NODES     = 2 * ELEMENTS;
    localparam int NODE_AW   = $clog2(NODES);
    localparam int PTR_W     = NODE_AW + 1;
    localparam int VALUE_W   = 32;
    localparam int SIGN_W    = 2;
    localparam int S_TDATA_W = ((2 * IDX_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SIGN_W + 7) / 8) * 8;

    localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
    localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
    localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

    localparam logic OP_CHANGE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CH_READ,
        ST_CH_WRITE,
        ST_Q_READ,
        ST_Q_ACC,
        ST_DONE
    } rpst_state_t;

    typedef struct packed {
        logic               en;
        logic [NODE_AW-1:0] addr;
        logic [SIGN_W-1:0]  data;
    } node_wr_t;

    typedef struct packed {
        logic [NODE_AW-1:0] addr_a;
        logic [NODE_AW-1:0] addr_b;
    } node_rd_t;

    function automatic logic [SIGN_W-1:0] sign_of(input logic [VALUE_W-1:0] v);
        logic [SIGN_W-1:0] s;
        if (v == '0) begin
            s = SIGN_ZERO;
        end else if (v[VALUE_W-1]) begin
            s = SIGN_NEG;
        end else begin
            s = SIGN_POS;
        end
        return s;
    endfunction

    function automatic logic [SIGN_W-1:0] sign_mul(input logic [SIGN_W-1:0] a,
                                                   input logic [SIGN_W-1:0] b);
        logic [SIGN_W-1:0] p;
        if (a == SIGN_ZERO || b == SIGN_ZERO) begin
            p = SIGN_ZERO;
        end else if (a[SIGN_W-1] ^ b[SIGN_W-1]) begin
            p = SIGN_NEG;
        end else begin
            p = SIGN_POS;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/range_product_sign_tree_core.sv =====
// Top level: sign-of-product tree over the element array with change and range query.
// Change: write the leaf, then read the sibling and write the parent at each level up to the root; no result word.
// Query: each loop pass reads both edge nodes, multiplies in the odd ones and climbs a level; then the result word.
// Reversed range: straight to the result word with the error flag set. One item in flight; the
// single node memory is read once per level.
// Reset: synchronous, active low; then a clearing pass sets every node to +1.
`timescale 1ns / 1ps
`default_nettype none

module range_product_sign_tree_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input word
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [9:0] first_index, [19:10] last_index, [51:20] new_value, [55:52] zero
    input  wire logic [rpst_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] op
    input  wire logic                              s_tuser,
    // result word
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [1:0] product_sign, [7:2] zero
    output logic [rpst_pkg::M_TDATA_W-1:0]         m_tdata,
    // [0] range_error
    output logic                                   m_tuser
);
    import rpst_pkg::*;

    rpst_state_t         state_reg, state_next;
    logic [NODE_AW-1:0]  clr_reg, clr_next;      // clearing pass address
    logic [NODE_AW-1:0]  node_reg, node_next;    // node just written on a change
    logic [SIGN_W-1:0]   cur_reg, cur_next;      // its sign value
    logic [PTR_W-1:0]    lo_reg, lo_next;        // half-open query bounds
    logic [PTR_W-1:0]    hi_reg, hi_next;
    logic [SIGN_W-1:0]   prod_reg, prod_next;    // running product / finished sign
    logic                err_reg, err_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SIGN_W-1:0]   m_sign_reg, m_sign_next;
    logic                m_err_reg, m_err_next;

    node_wr_t            wr;
    node_rd_t            rd;
    logic [SIGN_W-1:0]   rd_data_a, rd_data_b;

    logic [IDX_W-1:0]    in_first, in_last;
    logic [VALUE_W-1:0]  in_value;
    logic                in_op;
    logic                accept;
    logic [PTR_W-1:0]    hi_dec;
    logic [PTR_W-1:0]    lo_step, hi_step;
    logic [SIGN_W-1:0]   prod_a, prod_b;
    logic [NODE_AW-1:0]  parent;

    assign in_first = s_tdata[IDX_W-1:0];
    assign in_last  = s_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_tdata[2*IDX_W+VALUE_W-1:2*IDX_W];
    assign in_op    = s_tuser;

    assign accept   = s_tvalid && s_tready;

    // Query loop arithmetic: step odd bounds inwards, then climb one level.
    assign hi_dec   = hi_reg - PTR_W'(1);
    assign lo_step  = (lo_reg + PTR_W'(lo_reg[0])) >> 1;
    assign hi_step  = (hi_reg - PTR_W'(hi_reg[0])) >> 1;
    assign prod_a   = lo_reg[0] ? sign_mul(prod_reg, rd_data_a) : prod_reg;
    assign prod_b   = hi_reg[0] ? sign_mul(prod_a, rd_data_b) : prod_a;
    assign parent   = node_reg >> 1;

    rpst_node_store u_store (
        .aclk      (aclk),
        .wr        (wr),
        .rd        (rd),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge aclk) begin
        node_reg   <= node_next;
        cur_reg    <= cur_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        prod_reg   <= prod_next;
        err_reg    <= err_next;
        m_sign_reg <= m_sign_next;
        m_err_reg  <= m_err_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        node_next     = node_reg;
        cur_next      = cur_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        prod_next     = prod_reg;
        err_next      = err_reg;
        m_sign_next   = m_sign_reg;
        m_err_next    = m_err_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        wr            = '{en: 1'b0, addr: '0, data: SIGN_POS};
        rd            = '{addr_a: node_reg ^ NODE_AW'(1), addr_b: hi_dec[NODE_AW-1:0]};

        case (state_reg)
            ST_CLEAR: begin
                // Sweep every node to +1, one per cycle.
                wr = '{en: 1'b1, addr: clr_reg, data: SIGN_POS};
                clr_next = clr_reg + NODE_AW'(1);
                if (clr_reg == NODE_AW'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    if (in_op == OP_CHANGE) begin
                        // Write the leaf now, then recompute the ancestors.
                        node_next = NODE_AW'(ELEMENTS) + NODE_AW'(in_first);
                        cur_next  = sign_of(in_value);
                        wr = '{en: 1'b1, addr: NODE_AW'(ELEMENTS) + NODE_AW'(in_first),
                               data: sign_of(in_value)};
                        state_next = ST_CH_READ;
                    end else if (in_first > in_last) begin
                        // Reversed range: flag it, sign zero.
                        prod_next  = SIGN_ZERO;
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        lo_next    = PTR_W'(ELEMENTS) + PTR_W'(in_first);
                        hi_next    = PTR_W'(ELEMENTS) + PTR_W'(in_last) + PTR_W'(1);
                        prod_next  = SIGN_POS;
                        err_next   = 1'b0;
                        state_next = ST_Q_READ;
                    end
                end
            end
            ST_CH_READ: begin
                // Fetch the sibling of the node just written.
                rd.addr_a  = node_reg ^ NODE_AW'(1);
                state_next = ST_CH_WRITE;
            end
            ST_CH_WRITE: begin
                cur_next  = sign_mul(cur_reg, rd_data_a);
                node_next = parent;
                wr = '{en: 1'b1, addr: parent, data: sign_mul(cur_reg, rd_data_a)};
                if (parent == NODE_AW'(1)) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_CH_READ;
                end
            end
            ST_Q_READ: begin
                // Read both edge nodes; only odd bounds use theirs.
                rd.addr_a  = lo_reg[NODE_AW-1:0];
                rd.addr_b  = hi_dec[NODE_AW-1:0];
                state_next = ST_Q_ACC;
            end
            ST_Q_ACC: begin
                prod_next = prod_b;
                lo_next   = lo_step;
                hi_next   = hi_step;
                if (lo_step < hi_step) begin
                    state_next = ST_Q_READ;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the result register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_sign_next   = prod_reg;
                    m_err_next    = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - SIGN_W){1'b0}}, m_sign_reg};
    assign m_tuser  = m_err_reg;

endmodule

`default_nettype wire

// ===== rtl/rpst_node_store.sv =====
// Node sign memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module rpst_node_store (
    input  wire logic                                  aclk,
    input  wire rpst_pkg::node_wr_t                    wr,
    input  wire rpst_pkg::node_rd_t                    rd,
    output logic [rpst_pkg::SIGN_W-1:0]                rd_data_a,
    output logic [rpst_pkg::SIGN_W-1:0]                rd_data_b
);
    import rpst_pkg::*;

    logic [SIGN_W-1:0] mem [NODES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd.addr_a];
        rd_data_b <= mem[rd.addr_b];
    end

endmodule

`default_nettype wire
